/* rtl/indexed_linked_list_store_macros.svh */
// Assertion macros for the RTL of the indexed linked list store.
// No dependencies; included by ills_datapath, the module that carries assertions.
`ifndef INDEXED_LINKED_LIST_STORE_MACROS_SVH
`define INDEXED_LINKED_LIST_STORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILLS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ILLS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ills_pkg.sv */
// Package of the indexed linked list store: request, status and micro-op codes,
// and the structs between controller and datapath. No dependencies.
package ills_pkg;

    // request types
    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_DELETE  = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_WRITE   = 3'd3;
    localparam logic [2:0] REQ_APPEND  = 3'd4;
    localparam logic [2:0] REQ_PREPEND = 3'd5;

    // result status
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // datapath micro-ops
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LATCH    = 5'd1;
    localparam logic [4:0] OP_REJ      = 5'd2;
    localparam logic [4:0] OP_FULL     = 5'd3;
    localparam logic [4:0] OP_ALLOC_RD = 5'd4;
    localparam logic [4:0] OP_ALLOC    = 5'd5;
    localparam logic [4:0] OP_APP      = 5'd6;
    localparam logic [4:0] OP_PRE      = 5'd7;
    localparam logic [4:0] OP_WSTART   = 5'd8;
    localparam logic [4:0] OP_WSTEP    = 5'd9;
    localparam logic [4:0] OP_WEND     = 5'd10;
    localparam logic [4:0] OP_INS_RD   = 5'd11;
    localparam logic [4:0] OP_INS_W1   = 5'd12;
    localparam logic [4:0] OP_INS_W2   = 5'd13;
    localparam logic [4:0] OP_DF_RD    = 5'd14;
    localparam logic [4:0] OP_DF       = 5'd15;
    localparam logic [4:0] OP_DB_RD    = 5'd16;
    localparam logic [4:0] OP_DB       = 5'd17;
    localparam logic [4:0] OP_DM_RD    = 5'd18;
    localparam logic [4:0] OP_DM       = 5'd19;
    localparam logic [4:0] OP_RD_RD    = 5'd20;
    localparam logic [4:0] OP_RD       = 5'd21;
    localparam logic [4:0] OP_WR       = 5'd22;
    localparam logic [4:0] OP_HV_RD    = 5'd23;
    localparam logic [4:0] OP_TV_RD    = 5'd24;
    localparam logic [4:0] OP_TV       = 5'd25;

    typedef struct packed {
        logic [4:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       pos_ok;      // position below length
        logic       pos_ins_ok;  // position not above length
        logic       pos_zero;
        logic       pos_end;     // position equals length
        logic       pos_last;    // position equals length - 1
        logic       room;
        logic       walk_done;
    } t_dp_stat;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
    } t_hs_ctl;

endpackage

/* rtl/ills_req_if.sv */
// Request channel interface of the indexed linked list store.
// No dependencies.
interface ills_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  req_type;
    logic        [7:0]  position;
    logic signed [31:0] element_value;

    modport source (output valid, req_type, position, element_value, input ready);
    modport sink   (input valid, req_type, position, element_value, output ready);
endinterface

/* rtl/ills_rsp_if.sv */
// Response channel interface of the indexed linked list store.
// No dependencies.
interface ills_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] read_value;
    logic        [8:0]  list_length;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;

    modport source (output valid, status, read_value, list_length, head_value, tail_value,
                    input ready);
    modport sink   (input valid, status, read_value, list_length, head_value, tail_value,
                    output ready);
endinterface

/* rtl/ills_datapath.sv */
// Datapath of the indexed linked list store: node, link and free-stack memories,
// list pointers and result registers. Depends on ills_pkg and the macros header.
`include "indexed_linked_list_store_macros.svh"

module ills_datapath
    import ills_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic        [2:0]  i_req_type,
    input  logic        [7:0]  i_position,
    input  logic signed [31:0] i_element_value,
    output t_dp_stat           o_stat,
    output logic        [1:0]  o_status,
    output logic signed [31:0] o_read_value,
    output logic        [8:0]  o_list_length,
    output logic signed [31:0] o_head_value,
    output logic signed [31:0] o_tail_value
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // memories
    logic [VALUE_WIDTH-1:0] r_mem_val  [CAPACITY];
    logic [SW-1:0]          r_mem_next [CAPACITY];
    logic [SW-1:0]          r_mem_prev [CAPACITY];
    logic [SW-1:0]          r_mem_stk  [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_val_q;
    logic [SW-1:0]          r_next_q, r_prev_q, r_stk_q;

    // request and result registers
    logic [2:0]             r_req;
    logic [7:0]             r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [1:0]             r_status;
    logic [VALUE_WIDTH-1:0] r_rd, r_hval, r_tval;

    // list and allocator state
    logic [SW-1:0] r_head, r_tail, r_cur, r_nxt, r_new, r_steps;
    logic [CW-1:0] r_count, r_stk, r_fresh;
    logic          r_fwd, r_wfirst;

    logic [SW-1:0] link_q, cur_slot, new_slot;
    logic [PW-1:0] pos_ext, cnt_ext, tgt;
    logic          count_one;
    logic [CW:0]   slot_sum;
    logic          slots_ok;

    assign link_q    = r_fwd ? r_next_q : r_prev_q;
    assign cur_slot  = r_wfirst ? r_cur : link_q;
    assign new_slot  = (r_stk != '0) ? r_stk_q : SW'(r_fresh);
    assign pos_ext   = PW'(r_pos);
    assign cnt_ext   = PW'(r_count);
    assign tgt       = (r_req == REQ_INSERT) ? (pos_ext - PW'(1)) : pos_ext;
    assign count_one = (r_count == CW'(1));

    // slots handed out = recycled + in list, once a request has finished
    assign slot_sum  = (CW+1)'(r_stk) + (CW+1)'(r_count);
    assign slots_ok  = (slot_sum == (CW+1)'(r_fresh));

    // status to the controller
    always_comb begin
        o_stat.req        = r_req;
        o_stat.pos_ok     = pos_ext < cnt_ext;
        o_stat.pos_ins_ok = pos_ext <= cnt_ext;
        o_stat.pos_zero   = (r_pos == 8'd0);
        o_stat.pos_end    = pos_ext == cnt_ext;
        o_stat.pos_last   = (pos_ext + PW'(1)) == cnt_ext;
        o_stat.room       = r_count < CAP_C;
        o_stat.walk_done  = (r_steps == '0);
    end

    // memory port selection
    logic                   v_re, l_re, v_we, n_we, p_we, s_we;
    logic [SW-1:0]          v_ra, l_ra, v_wa, n_wa, p_wa, s_wa;
    logic [VALUE_WIDTH-1:0] v_wd;
    logic [SW-1:0]          n_wd, p_wd, s_wd;

    always_comb begin
        v_re = 1'b0; v_ra = r_cur;
        l_re = 1'b0; l_ra = r_cur;
        v_we = 1'b0; v_wa = r_cur; v_wd = r_val;
        n_we = 1'b0; n_wa = r_cur; n_wd = r_new;
        p_we = 1'b0; p_wa = r_cur; p_wd = r_new;
        s_we = 1'b0; s_wa = SW'(r_stk); s_wd = r_cur;
        unique case (i_cmd.op)
            OP_ALLOC: begin
                v_we = 1'b1; v_wa = new_slot;
            end
            OP_APP: begin
                n_we = (r_count != '0); n_wa = r_tail; n_wd = r_new;
                p_we = (r_count != '0); p_wa = r_new;  p_wd = r_tail;
            end
            OP_PRE: begin
                n_we = (r_count != '0); n_wa = r_new;  n_wd = r_head;
                p_we = (r_count != '0); p_wa = r_head; p_wd = r_new;
            end
            OP_WSTEP: begin
                l_re = 1'b1; l_ra = cur_slot;
            end
            OP_INS_RD, OP_DM_RD: begin
                l_re = 1'b1; l_ra = r_cur;
            end
            OP_INS_W1: begin
                n_we = 1'b1; n_wa = r_new; n_wd = r_next_q;
                p_we = 1'b1; p_wa = r_new; p_wd = r_cur;
            end
            OP_INS_W2: begin
                n_we = 1'b1; n_wa = r_cur; n_wd = r_new;
                p_we = 1'b1; p_wa = r_nxt; p_wd = r_new;
            end
            OP_DF_RD: begin
                l_re = 1'b1; l_ra = r_head;
            end
            OP_DB_RD: begin
                l_re = 1'b1; l_ra = r_tail;
            end
            OP_DF: begin
                s_we = 1'b1; s_wd = r_head;
            end
            OP_DB: begin
                s_we = 1'b1; s_wd = r_tail;
            end
            OP_DM: begin
                n_we = 1'b1; n_wa = r_prev_q; n_wd = r_next_q;
                p_we = 1'b1; p_wa = r_next_q; p_wd = r_prev_q;
                s_we = 1'b1; s_wd = r_cur;
            end
            OP_RD_RD: begin
                v_re = 1'b1; v_ra = r_cur;
            end
            OP_WR: begin
                v_we = 1'b1; v_wa = r_cur;
            end
            OP_HV_RD: begin
                v_re = 1'b1; v_ra = r_head;
            end
            OP_TV_RD: begin
                v_re = 1'b1; v_ra = r_tail;
            end
            default: begin
            end
        endcase
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_mem_val[v_wa] <= v_wd;
        end
        if (v_re) begin
            r_val_q <= r_mem_val[v_ra];
        end
    end

    // link memories, both read at one address
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem_next[n_wa] <= n_wd;
        end
        if (p_we) begin
            r_mem_prev[p_wa] <= p_wd;
        end
        if (l_re) begin
            r_next_q <= r_mem_next[l_ra];
            r_prev_q <= r_mem_prev[l_ra];
        end
    end

    // free stack of recycled slots
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem_stk[s_wa] <= s_wd;
        end
        if (i_cmd.op == OP_ALLOC_RD) begin
            r_stk_q <= r_mem_stk[SW'(r_stk - CW'(1))];
        end
    end

    // list pointers, counts and allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_stk   <= '0;
            r_fresh <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_ALLOC: begin
                    if (r_stk != '0) begin
                        r_stk <= r_stk - CW'(1);
                    end else begin
                        r_fresh <= r_fresh + CW'(1);
                    end
                end
                OP_APP: begin
                    if (r_count == '0) begin
                        r_head <= r_new;
                    end
                    r_tail  <= r_new;
                    r_count <= r_count + CW'(1);
                end
                OP_PRE: begin
                    if (r_count == '0) begin
                        r_tail <= r_new;
                    end
                    r_head  <= r_new;
                    r_count <= r_count + CW'(1);
                end
                OP_INS_W2: begin
                    r_count <= r_count + CW'(1);
                end
                OP_DF: begin
                    r_head  <= count_one ? '0 : r_next_q;
                    if (count_one) begin
                        r_tail <= '0;
                    end
                    r_count <= r_count - CW'(1);
                    r_stk   <= r_stk + CW'(1);
                end
                OP_DB: begin
                    r_tail  <= count_one ? '0 : r_prev_q;
                    if (count_one) begin
                        r_head <= '0;
                    end
                    r_count <= r_count - CW'(1);
                    r_stk   <= r_stk + CW'(1);
                end
                OP_DM: begin
                    r_count <= r_count - CW'(1);
                    r_stk   <= r_stk + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // walk, request and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_req    <= i_req_type;
                r_pos    <= i_position;
                r_val    <= VALUE_WIDTH'(i_element_value);
                r_status <= ST_DONE;
                r_rd     <= '0;
            end
            OP_REJ: r_status <= ST_REJECT;
            OP_FULL: r_status <= ST_FULL;
            OP_ALLOC: r_new <= new_slot;
            OP_WSTART: begin
                r_wfirst <= 1'b1;
                if (tgt < (cnt_ext >> 1)) begin
                    r_cur   <= r_head;
                    r_steps <= SW'(tgt);
                    r_fwd   <= 1'b1;
                end else begin
                    r_cur   <= r_tail;
                    r_steps <= SW'(cnt_ext - PW'(1) - tgt);
                    r_fwd   <= 1'b0;
                end
            end
            OP_WSTEP: begin
                r_wfirst <= 1'b0;
                r_steps  <= r_steps - SW'(1);
            end
            OP_WEND: begin
                r_cur    <= cur_slot;
                r_wfirst <= 1'b1;
            end
            OP_INS_W1: r_nxt <= r_next_q;
            OP_RD: r_rd <= r_val_q;
            OP_TV_RD: r_hval <= (r_count == '0) ? '0 : r_val_q;
            OP_TV: r_tval <= (r_count == '0) ? '0 : r_val_q;
            default: begin
            end
        endcase
    end

    // result payload
    assign o_status      = r_status;
    assign o_read_value  = 32'(r_rd);
    assign o_list_length = 9'(r_count);
    assign o_head_value  = 32'(r_hval);
    assign o_tail_value  = 32'(r_tval);

    `ILLS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "length above capacity")
    `ILLS_ASSERT_IMP(a_slot_sum, i_clk, i_rst_n, i_cmd.op == OP_LATCH, slots_ok, "slot accounting")
    `ILLS_ASSERT_IMP(a_walk_step, i_clk, i_rst_n, i_cmd.op == OP_WSTEP, r_steps != '0, "walk stepped past target")
    `ILLS_ASSERT_IMP(a_alloc_room, i_clk, i_rst_n, i_cmd.op == OP_ALLOC, r_count < CAP_C, "allocation on full pool")

endmodule

/* rtl/ills_ctrl.sv */
// Controller of the indexed linked list store: sequences each request through
// datapath micro-ops. Depends on ills_pkg.
module ills_ctrl
    import ills_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output t_hs_ctl  o_hs
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_ARD   = 5'd2;
    localparam logic [4:0] S_ALLOC = 5'd3;
    localparam logic [4:0] S_APP   = 5'd4;
    localparam logic [4:0] S_PRE   = 5'd5;
    localparam logic [4:0] S_WS    = 5'd6;
    localparam logic [4:0] S_WALK  = 5'd7;
    localparam logic [4:0] S_IRD   = 5'd8;
    localparam logic [4:0] S_IW1   = 5'd9;
    localparam logic [4:0] S_IW2   = 5'd10;
    localparam logic [4:0] S_DFRD  = 5'd11;
    localparam logic [4:0] S_DF    = 5'd12;
    localparam logic [4:0] S_DBRD  = 5'd13;
    localparam logic [4:0] S_DB    = 5'd14;
    localparam logic [4:0] S_DMRD  = 5'd15;
    localparam logic [4:0] S_DM    = 5'd16;
    localparam logic [4:0] S_RRD   = 5'd17;
    localparam logic [4:0] S_RD    = 5'd18;
    localparam logic [4:0] S_WR    = 5'd19;
    localparam logic [4:0] S_HV    = 5'd20;
    localparam logic [4:0] S_TV    = 5'd21;
    localparam logic [4:0] S_TVC   = 5'd22;
    localparam logic [4:0] S_OUT   = 5'd23;

    logic [4:0] r_state, n_state;

    // next state and micro-op
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_hs        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_hs.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_HV;
                priority case (i_stat.req)
                    REQ_INSERT: begin
                        if (!i_stat.pos_ins_ok) begin
                            o_cmd.op = OP_REJ;
                        end else if (!i_stat.room) begin
                            o_cmd.op = OP_FULL;
                        end else begin
                            n_state = S_ARD;
                        end
                    end
                    REQ_DELETE: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.op = OP_REJ;
                        end else if (i_stat.pos_zero) begin
                            n_state = S_DFRD;
                        end else if (i_stat.pos_last) begin
                            n_state = S_DBRD;
                        end else begin
                            n_state = S_WS;
                        end
                    end
                    REQ_READ, REQ_WRITE: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.op = OP_REJ;
                        end else begin
                            n_state = S_WS;
                        end
                    end
                    REQ_APPEND, REQ_PREPEND: begin
                        if (!i_stat.room) begin
                            o_cmd.op = OP_FULL;
                        end else begin
                            n_state = S_ARD;
                        end
                    end
                    default: o_cmd.op = OP_REJ;
                endcase
            end
            S_ARD: begin
                o_cmd.op = OP_ALLOC_RD;
                n_state  = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                if (i_stat.req == REQ_PREPEND
                    || (i_stat.req == REQ_INSERT && i_stat.pos_zero)) begin
                    n_state = S_PRE;
                end else if (i_stat.req == REQ_APPEND || i_stat.pos_end) begin
                    n_state = S_APP;
                end else begin
                    n_state = S_WS;
                end
            end
            S_APP: begin
                o_cmd.op = OP_APP;
                n_state  = S_HV;
            end
            S_PRE: begin
                o_cmd.op = OP_PRE;
                n_state  = S_HV;
            end
            S_WS: begin
                o_cmd.op = OP_WSTART;
                n_state  = S_WALK;
            end
            // one link a cycle until the target slot is reached
            S_WALK: begin
                if (!i_stat.walk_done) begin
                    o_cmd.op = OP_WSTEP;
                end else begin
                    o_cmd.op = OP_WEND;
                    priority case (i_stat.req)
                        REQ_INSERT: n_state = S_IRD;
                        REQ_DELETE: n_state = S_DMRD;
                        REQ_READ:   n_state = S_RRD;
                        default:    n_state = S_WR;
                    endcase
                end
            end
            S_IRD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = S_IW1;
            end
            S_IW1: begin
                o_cmd.op = OP_INS_W1;
                n_state  = S_IW2;
            end
            S_IW2: begin
                o_cmd.op = OP_INS_W2;
                n_state  = S_HV;
            end
            S_DFRD: begin
                o_cmd.op = OP_DF_RD;
                n_state  = S_DF;
            end
            S_DF: begin
                o_cmd.op = OP_DF;
                n_state  = S_HV;
            end
            S_DBRD: begin
                o_cmd.op = OP_DB_RD;
                n_state  = S_DB;
            end
            S_DB: begin
                o_cmd.op = OP_DB;
                n_state  = S_HV;
            end
            S_DMRD: begin
                o_cmd.op = OP_DM_RD;
                n_state  = S_DM;
            end
            S_DM: begin
                o_cmd.op = OP_DM;
                n_state  = S_HV;
            end
            S_RRD: begin
                o_cmd.op = OP_RD_RD;
                n_state  = S_RD;
            end
            S_RD: begin
                o_cmd.op = OP_RD;
                n_state  = S_HV;
            end
            S_WR: begin
                o_cmd.op = OP_WR;
                n_state  = S_HV;
            end
            S_HV: begin
                o_cmd.op = OP_HV_RD;
                n_state  = S_TV;
            end
            S_TV: begin
                o_cmd.op = OP_TV_RD;
                n_state  = S_TVC;
            end
            S_TVC: begin
                o_cmd.op = OP_TV;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_hs.out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/indexed_linked_list_store.sv */
// Top level of the indexed linked list store: controller plus datapath on
// request/response channels. Depends on ills_pkg, both interfaces and both modules.
//
//  channel | dir | handshake   | payload
//  i_req   | in  | valid/ready | req_type, position, element_value
//  o_rsp   | out | valid/ready | status, read_value, list_length, head/tail value
//
// One transaction at a time. Appends, prepends and end deletes need no walk; positional
// requests walk first. The walk follows one link per cycle from the nearer end, up to
// CAPACITY/2 - 1 links; the link memories' single read port sets that rate.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
// A stalled response holds in its registers; i_req.ready stays low until it is taken.
module indexed_linked_list_store
    import ills_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ills_req_if.sink       i_req,
    ills_rsp_if.source     o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_hs_ctl  hs;

    assign i_req.ready = hs.in_ready;
    assign o_rsp.valid = hs.out_valid;

    ills_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_hs        (hs)
    );

    ills_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_req_type      (i_req.req_type),
        .i_position      (i_req.position),
        .i_element_value (i_req.element_value),
        .o_stat          (stat),
        .o_status        (o_rsp.status),
        .o_read_value    (o_rsp.read_value),
        .o_list_length   (o_rsp.list_length),
        .o_head_value    (o_rsp.head_value),
        .o_tail_value    (o_rsp.tail_value)
    );

endmodule

/* tb/sv/tb_indexed_linked_list_store.sv */
// Testbench of the indexed linked list store: drives requests, predicts each
// response with a queue-based list model. Depends on the top level, ills_pkg, ills_req_if, ills_rsp_if.
`timescale 1ns / 100ps

module tb_indexed_linked_list_store;
    import ills_pkg::*;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  position;
        logic [31:0] element_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [8:0]  list_length;
        logic [31:0] head_value;
        logic [31:0] tail_value;
    } t_rsp;

    localparam int POOL = 256;

    logic i_clk;
    logic i_rst_n;

    ills_req_if req_ch ();
    ills_rsp_if rsp_ch ();

    indexed_linked_list_store i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    logic [31:0] list_vals[$];     // predicted list contents, head first
    int          error_count = 0;
    bit          calm = 0;         // no idling in the last part of the run
    int          src_gap = 0;
    int          snk_gap = 0;

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // list behavior: one response per request
    function automatic t_rsp list_apply(t_req r);
        t_rsp o;
        int   n;
        n = list_vals.size();
        o = '0;
        o.status = ST_DONE;
        case (r.req_type)
            REQ_INSERT: begin
                if (r.position > n) o.status = ST_REJECT;
                else if (n >= POOL) o.status = ST_FULL;
                else list_vals.insert(r.position, r.element_value);
            end
            REQ_DELETE: begin
                if (r.position >= n) o.status = ST_REJECT;
                else list_vals.delete(r.position);
            end
            REQ_READ: begin
                if (r.position >= n) o.status = ST_REJECT;
                else o.read_value = list_vals[r.position];
            end
            REQ_WRITE: begin
                if (r.position >= n) o.status = ST_REJECT;
                else list_vals[r.position] = r.element_value;
            end
            REQ_APPEND: begin
                if (n >= POOL) o.status = ST_FULL;
                else list_vals.push_back(r.element_value);
            end
            REQ_PREPEND: begin
                if (n >= POOL) o.status = ST_FULL;
                else list_vals.push_front(r.element_value);
            end
            default: o.status = ST_REJECT;
        endcase
        n = list_vals.size();
        o.list_length = n[8:0];
        if (n > 0) begin
            o.head_value = list_vals[0];
            o.tail_value = list_vals[n-1];
        end
        return o;
    endfunction

    function automatic t_req mk_req(logic [2:0] t, int p, logic [31:0] v);
        t_req r;
        r.req_type      = t;
        r.position      = p[7:0];
        r.element_value = v;
        return r;
    endfunction

    // position biased toward a valid one for the current predicted length
    function automatic int pick_pos(int len, bit ins);
        int lim;
        lim = ins ? len : len - 1;
        if ($urandom_range(0, 9) == 0 || lim < 0) return $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return lim;
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(req_ch.valid && pending_reqs.size() == 1 && 0)) begin
                t_req r;
                r = pending_reqs.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.req_type      <= r.req_type;
                req_ch.position      <= r.position;
                req_ch.element_value <= r.element_value;
                expected_rsps.push_back(list_apply(r));
                if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 16);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and response-side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_rsp got;
                t_rsp want;
                got = {rsp_ch.status, rsp_ch.read_value, rsp_ch.list_length,
                       rsp_ch.head_value, rsp_ch.tail_value};
                if (expected_rsps.size() == 0) begin
                    $display("%0t: response with none expected: %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value exp %h got %h", $time,
                                 want.read_value, got.read_value);
                        error_count++;
                    end
                    if (got.list_length !== want.list_length) begin
                        $display("%0t: list_length exp %0d got %0d", $time,
                                 want.list_length, got.list_length);
                        error_count++;
                    end
                    if (got.head_value !== want.head_value) begin
                        $display("%0t: head_value exp %h got %h", $time,
                                 want.head_value, got.head_value);
                        error_count++;
                    end
                    if (got.tail_value !== want.tail_value) begin
                        $display("%0t: tail_value exp %h got %h", $time,
                                 want.tail_value, got.tail_value);
                        error_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap <= $urandom_range(1, 16) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus: the pending queue is filled ahead; the prediction runs at issue,
    // so positions are chosen against a shadow length tracked here
    initial begin
        int shadow;
        int k;
        int t;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.position      = '0;
        req_ch.element_value = '0;
        rsp_ch.ready         = 1'b0;
        i_rst_n              = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list rejects, ends, extremes, unknown codes
        pending_reqs.push_back(mk_req(REQ_DELETE, 0, 0));
        pending_reqs.push_back(mk_req(REQ_READ, 0, 0));
        pending_reqs.push_back(mk_req(REQ_WRITE, 0, 32'h1));
        pending_reqs.push_back(mk_req(REQ_INSERT, 1, 32'h2));
        pending_reqs.push_back(mk_req(REQ_APPEND, 0, 32'h8000_0000));
        pending_reqs.push_back(mk_req(REQ_PREPEND, 255, 32'h7fff_ffff));
        pending_reqs.push_back(mk_req(REQ_INSERT, 0, 32'hffff_ffff));
        pending_reqs.push_back(mk_req(REQ_INSERT, 3, 32'h5555_5555));
        pending_reqs.push_back(mk_req(REQ_INSERT, 2, 32'haaaa_aaaa));
        pending_reqs.push_back(mk_req(REQ_INSERT, 9, 32'h3));
        pending_reqs.push_back(mk_req(REQ_READ, 2, 0));
        pending_reqs.push_back(mk_req(REQ_READ, 5, 0));
        pending_reqs.push_back(mk_req(REQ_WRITE, 1, 32'h0));
        pending_reqs.push_back(mk_req(REQ_READ, 1, 0));
        pending_reqs.push_back(mk_req(3'd6, 0, 32'h1234));
        pending_reqs.push_back(mk_req(3'd7, 255, 32'hffff_ffff));
        pending_reqs.push_back(mk_req(REQ_DELETE, 2, 0));
        pending_reqs.push_back(mk_req(REQ_DELETE, 3, 0));
        pending_reqs.push_back(mk_req(REQ_DELETE, 0, 0));
        pending_reqs.push_back(mk_req(REQ_DELETE, 1, 0));
        shadow = 1;

        // fill the pool, then probe full behavior at every kind of add
        for (k = 0; k < 255; k++) begin
            pending_reqs.push_back(mk_req(k[0] ? REQ_APPEND : REQ_PREPEND, 0, $urandom()));
        end
        shadow = 256;
        pending_reqs.push_back(mk_req(REQ_APPEND, 0, $urandom()));
        pending_reqs.push_back(mk_req(REQ_PREPEND, 0, $urandom()));
        pending_reqs.push_back(mk_req(REQ_INSERT, 128, $urandom()));
        pending_reqs.push_back(mk_req(REQ_READ, 255, 0));
        pending_reqs.push_back(mk_req(REQ_WRITE, 127, 32'h8000_0000));
        pending_reqs.push_back(mk_req(REQ_READ, 127, 0));
        pending_reqs.push_back(mk_req(REQ_DELETE, 200, 0));
        pending_reqs.push_back(mk_req(REQ_INSERT, 255, 32'h7fff_ffff));
        pending_reqs.push_back(mk_req(REQ_INSERT, 255, 32'h1)); // full again

        // drain part of it so the random part works on shorter lists
        for (k = 0; k < 120; k++)
            pending_reqs.push_back(mk_req(REQ_DELETE, $urandom_range(0, 255 - k), 0));
        shadow = 136;

        // random mix
        for (k = 0; k < 150; k++) begin
            if (k == 120) calm = 1;
            t = $urandom_range(0, 19);
            if (t < 4)
                pending_reqs.push_back(mk_req(REQ_INSERT, pick_pos(shadow, 1), $urandom()));
            else if (t < 8)
                pending_reqs.push_back(mk_req(REQ_DELETE, pick_pos(shadow, 0), 0));
            else if (t < 11)
                pending_reqs.push_back(mk_req(REQ_READ, pick_pos(shadow, 0), $urandom()));
            else if (t < 14)
                pending_reqs.push_back(mk_req(REQ_WRITE, pick_pos(shadow, 0), $urandom()));
            else if (t < 16)
                pending_reqs.push_back(mk_req(REQ_APPEND, $urandom_range(0, 255), $urandom()));
            else if (t < 18)
                pending_reqs.push_back(mk_req(REQ_PREPEND, $urandom_range(0, 255), $urandom()));
            else
                pending_reqs.push_back(mk_req(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                                              $urandom()));
            // keep the shadow length in step once the queue drains to this point
            wait (pending_reqs.size() == 0);
            shadow = list_vals.size();
        end

        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (300) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_indexed_linked_list_store: done, clean");
        else
            $display("tb_indexed_linked_list_store: done, errors");
        $finish;
    end

    // run limit: ample time for ~550 items with stalls, many times over
    initial begin
        #20ms;
        $display("tb_indexed_linked_list_store: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ills_pkg.sv
rtl/ills_req_if.sv
rtl/ills_rsp_if.sv
rtl/ills_datapath.sv
rtl/ills_ctrl.sv
rtl/indexed_linked_list_store.sv
tb/sv/tb_indexed_linked_list_store.sv
